FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also checks the cycle after reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/walc_pkg.sv
// types and codes of the journal controller
// no dependencies
package walc_pkg;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_END    = 2'd1;
   localparam logic [1:0] CMD_RECORD = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_COPY    = 2'd1;
   localparam logic [1:0] KIND_HEADER  = 2'd2;
   localparam logic [1:0] KIND_INSTALL = 2'd3;

   localparam logic [2:0] STAT_GRANTED      = 3'd0;
   localparam logic [2:0] STAT_MUST_WAIT    = 3'd1;
   localparam logic [2:0] STAT_ABSORBED     = 3'd2;
   localparam logic [2:0] STAT_APPENDED     = 3'd3;
   localparam logic [2:0] STAT_LOG_FULL     = 3'd4;
   localparam logic [2:0] STAT_OUTSIDE      = 3'd5;
   localparam logic [2:0] STAT_END_NO_BEGIN = 3'd6;

   localparam logic [1:0] CSR_LOG_AREA_START = 2'd0;
   localparam logic [1:0] CSR_RESERVE        = 2'd1;

   localparam logic [4:0] RESERVE_RESET = 5'd10;
   localparam logic [4:0] OPEN_MAX      = 5'd31;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] block_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [31:0] source_block;
      logic [31:0] destination_block;
      logic [4:0]  header_count;
      logic        pin_or_unpin;
      logic        last_result;
   } rsp_type;

endpackage

FILE: hw/rtl/walc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module walc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 30
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/walc_front.sv
// front end: accepts request beats, drops unused commands, two-entry queue
// depends on walc_pkg
module walc_front
   import walc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_pop,
   output req_type q_item
);

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && (req_data.cmd != CMD_UNUSED);
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = req_data;
         wr_ptr_in          = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/walc_back.sv
// back end: journal state, header table search, commit sequencer, result register
// depends on walc_pkg and walc_ram
module walc_back
   import walc_pkg::*;
#(
   parameter int LOG_CAPACITY = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_pop,
   input  req_type     q_item,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int CW = $clog2(LOG_CAPACITY + 1);
   localparam int AW = (LOG_CAPACITY > 1) ? $clog2(LOG_CAPACITY) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_STATUS, ST_CP_RD, ST_CP_EMIT,
      ST_HDR_FULL, ST_IN_RD, ST_IN_EMIT, ST_HDR_ZERO
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  open_ff, open_in;
   logic [CW-1:0] logged_ff, logged_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        pend_ff, pend_in;
   logic        commit_ff, commit_in;
   logic [31:0] blk_ff, blk_in;
   logic [2:0]  stat_ff, stat_in;
   logic        pin_ff, pin_in;
   logic        last_ff, last_in;
   logic [31:0] start_ff, start_in;
   logic [4:0]  reserve_ff, reserve_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic          ram_we, ram_re;
   logic [31:0]   ram_rdata;
   logic          out_free;
   logic [5:0]    open_p1;
   logic [10:0]   prod;
   logic [11:0]   need;
   logic [31:0]   slot;
   logic [CW-1:0] idx_next;

   walc_ram #(.WIDTH(32), .DEPTH(LOG_CAPACITY)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (logged_ff[AW-1:0]),
      .wr_data (blk_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign open_p1  = {1'b0, open_ff} + 6'd1;
   assign prod     = 11'(open_p1) * 11'(reserve_ff);
   assign need     = 12'(prod) + 12'(logged_ff);
   assign slot     = start_ff + 32'(idx_ff) + 32'd1;
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      logged_in    = logged_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      commit_in    = commit_ff;
      blk_in       = blk_ff;
      stat_in      = stat_ff;
      pin_in       = pin_ff;
      last_in      = last_ff;
      start_in     = start_ff;
      reserve_in   = reserve_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_LOG_AREA_START: start_in   = csr_wdata;
            CSR_RESERVE:        reserve_in = csr_wdata[4:0];
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               blk_in    = q_item.block_number;
               last_in   = 1'b1;
               pin_in    = 1'b0;
               commit_in = 1'b0;
               state_in  = ST_STATUS;
               unique case (q_item.cmd)
                  CMD_BEGIN: begin
                     if (need > 12'(LOG_CAPACITY) || open_ff == OPEN_MAX) begin
                        stat_in = STAT_MUST_WAIT;
                     end else begin
                        open_in = open_ff + 5'd1;
                        stat_in = STAT_GRANTED;
                     end
                  end
                  CMD_END: begin
                     if (open_ff == 5'd0) begin
                        stat_in = STAT_END_NO_BEGIN;
                     end else begin
                        open_in = open_ff - 5'd1;
                        stat_in = STAT_GRANTED;
                        if (open_ff == 5'd1 && logged_ff != '0) begin
                           commit_in = 1'b1;
                           last_in   = 1'b0;
                        end
                     end
                  end
                  CMD_RECORD: begin
                     if (logged_ff >= CW'(LOG_CAPACITY)) begin
                        stat_in = STAT_LOG_FULL;
                     end else if (open_ff == 5'd0) begin
                        stat_in = STAT_OUTSIDE;
                     end else begin
                        idx_in   = '0;
                        pend_in  = 1'b0;
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (pend_ff && ram_rdata == blk_ff) begin
               stat_in  = STAT_ABSORBED;
               state_in = ST_STATUS;
            end else if (idx_ff != logged_ff) begin
               ram_re  = 1'b1;
               idx_in  = idx_next;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               ram_we    = 1'b1;
               logged_in = logged_ff + CW'(1);
               stat_in   = STAT_APPENDED;
               pin_in    = 1'b1;
               state_in  = ST_STATUS;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_STATUS, stat_ff, 32'd0, 32'd0, 5'd0, pin_ff, last_ff};
               idx_in       = '0;
               state_in     = commit_ff ? ST_CP_RD : ST_IDLE;
            end
         end
         ST_CP_RD: begin
            ram_re   = 1'b1;
            state_in = ST_CP_EMIT;
         end
         ST_CP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_COPY, STAT_GRANTED, ram_rdata, slot, 5'd0, 1'b0, 1'b0};
               if (idx_next == logged_ff) begin
                  idx_in   = '0;
                  state_in = ST_HDR_FULL;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_CP_RD;
               end
            end
         end
         ST_HDR_FULL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_HEADER, STAT_GRANTED, 32'd0, start_ff,
                                5'(logged_ff), 1'b0, 1'b0};
               state_in     = ST_IN_RD;
            end
         end
         ST_IN_RD: begin
            ram_re   = 1'b1;
            state_in = ST_IN_EMIT;
         end
         ST_IN_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_INSTALL, STAT_GRANTED, slot, ram_rdata, 5'd0, 1'b1, 1'b0};
               if (idx_next == logged_ff) begin
                  state_in = ST_HDR_ZERO;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_IN_RD;
               end
            end
         end
         ST_HDR_ZERO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_HEADER, STAT_GRANTED, 32'd0, start_ff, 5'd0, 1'b0, 1'b1};
               logged_in    = '0;
               commit_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      blk_ff  <= blk_in;
      stat_ff <= stat_in;
      pin_ff  <= pin_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 5'd0;
         logged_ff    <= '0;
         pend_ff      <= 1'b0;
         commit_ff    <= 1'b0;
         start_ff     <= 32'd0;
         reserve_ff   <= RESERVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         logged_ff    <= logged_in;
         pend_ff      <= pend_in;
         commit_ff    <= commit_in;
         start_ff     <= start_in;
         reserve_ff   <= reserve_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/write_ahead_log_controller.sv
// top level of the write-ahead journal controller with group commit
// depends on walc_pkg, walc_front, walc_back (and walc_ram below it)
//
// usage
//  - req channel: one beat per command (begin, end, record block write);
//    cmd 3 is taken and dropped without any result beat
//  - rsp channel: one status beat per command; the end that closes the last
//    open operation with blocks logged adds 2n+2 commit beats (copy to slot,
//    header with count, install home with unpin, header with zero)
//  - last_result marks the final beat caused by a command
//  - csr channel: always ready; index 0 log area start, 1 reserve per
//    operation; write only while the block is idle
//  - status for begin, end and a rejected record passes the queue, the
//    sequencer state and the output register; a record first walks the
//    header table one entry a cycle, with n blocks logged
//  - a commit does a table read, then output, for each copy or install
//    beat, and only output for each header beat
//  - a two-entry queue parts the front from the sequencer, so requests keep
//    being taken while a result waits in the output register
//  - reset: no open operation, empty log, log start 0, reserve 10; the
//    header table holds no valid data until written
//  - when rsp_stall is high the output beat holds and the sequencer waits;
//    req_stall rises once the queue is full
module write_ahead_log_controller
   import walc_pkg::*;
#(
   parameter int LOG_CAPACITY = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // queue between front and sequencer
   logic    q_valid;
   logic    q_pop;
   req_type q_item;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   walc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   // journal state, table search and commit walk
   walc_back #(.LOG_CAPACITY(LOG_CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/walc_checker.sv
// port-level checks of the journal controller, bound to the top level
// depends on walc_pkg and assert_macros.svh
`include "assert_macros.svh"

module walc_checker
   import walc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // no result right out of reset
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "result beat right after reset")

   // only the zero header closes a commit, the counted header never does
   `ASSERT_IMPLY(a_header_last, clock, reset, rsp_valid && rsp_data.kind == KIND_HEADER, rsp_data.last_result == (rsp_data.header_count == 5'd0), "header beat with wrong last flag")

   // after the counted header leaves, installs follow and no status is shown next
   `ASSERT_NEXT(a_header_then_install, clock, reset, rsp_valid && !rsp_stall && rsp_data.kind == KIND_HEADER && rsp_data.header_count != 5'd0, !(rsp_valid && rsp_data.kind == KIND_STATUS), "status beat inside a commit")

endmodule

bind write_ahead_log_controller walc_checker u_walc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
